// ===== hdl/srs_pkg.sv =====
// shared types, codes and sizes of the selective-repeat sender scoreboard
package srs_pkg;

  localparam int unsigned MaxChunks = 256;
  localparam int unsigned IdxW      = $clog2(MaxChunks);
  localparam int unsigned CntW      = IdxW + 1;
  localparam int unsigned StampW    = 32;
  localparam int unsigned AckW      = 9;
  localparam int unsigned OpcW      = 3;

  localparam logic [OpcW-1:0] OPC_CLEAR = 3'd0;
  localparam logic [OpcW-1:0] OPC_TICK  = 3'd1;
  localparam logic [OpcW-1:0] OPC_SEND  = 3'd2;
  localparam logic [OpcW-1:0] OPC_ACK   = 3'd3;
  localparam logic [OpcW-1:0] OPC_CLOSE = 3'd4;

  localparam logic [AckW-1:0] KILL_ACK = 9'h1FF;

  localparam logic CFG_NUM_CHUNKS = 1'b0;
  localparam logic CFG_WAIT_TICKS = 1'b1;

  localparam logic [CntW-1:0]   DefChunks = 9'd1;
  localparam logic [StampW-1:0] DefWait   = 32'd100000;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_SEND,
    ACT_DONE
  } srs_action_e;

  typedef enum logic [1:0] {
    ST_NOT_SENT,
    ST_FAILED,
    ST_ACKED
  } srs_status_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_TICK,
    CMD_SEND,
    CMD_ACK,
    CMD_CLOSE
  } srs_cmd_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_PICK,
    BK_ACK_WR,
    BK_SETTLE,
    BK_FIN
  } srs_bk_state_e;

  typedef struct packed {
    srs_cmd_e        op;
    logic            kill_ack;
    logic [IdxW-1:0] seq;
  } srs_cmd_t;

  typedef struct packed {
    srs_action_e     action;
    logic [IdxW-1:0] seq;
    logic            kill;
    logic [CntW-1:0] acked;
  } srs_res_t;

endpackage

// ===== hdl/srs_front.sv =====
// front end: accepts input words, classifies them and queues commands
module srs_front import srs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CntW-1:0] n_i,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [15:0]     s_axis_tdata,  // ack_seq
  input  logic [2:0]      s_axis_tuser,  // opcode
  output logic            cmd_valid_o,
  output srs_cmd_t        cmd_o,
  input  logic            cmd_pop_i
);

  srs_cmd_t        fifo_q [2];
  logic            wptr_q, wptr_d;
  logic            rptr_q, rptr_d;
  logic [1:0]      cnt_q, cnt_d;
  srs_cmd_t        cls;
  logic [AckW-1:0] ack_raw;
  logic            is_kill;
  logic            in_rng;
  logic            push;
  logic            pop;

  assign ack_raw = s_axis_tdata[AckW-1:0];
  assign is_kill = (ack_raw == KILL_ACK);
  assign in_rng  = (ack_raw < n_i);

  always_comb begin
    cls.kill_ack = is_kill;
    cls.seq      = ack_raw[IdxW-1:0];
    unique case (s_axis_tuser)
      OPC_CLEAR: cls.op = CMD_CLEAR;
      OPC_TICK:  cls.op = CMD_TICK;
      OPC_SEND:  cls.op = CMD_SEND;
      OPC_ACK:   cls.op = (is_kill || in_rng) ? CMD_ACK : CMD_NONE;
      OPC_CLOSE: cls.op = CMD_CLOSE;
      default:   cls.op = CMD_NONE;
    endcase
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = (cnt_q != 2'd0);
  assign pop           = cmd_pop_i && cmd_valid_o;
  assign cmd_o         = fifo_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = ~wptr_q;
    end
    if (pop) begin
      rptr_d = ~rptr_q;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= cls;
    end
  end

endmodule

// ===== hdl/srs_back.sv =====
// back end: chunk status and stamp memories, scan sequencer and result register
module srs_back import srs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CntW-1:0]   n_i,
  input  logic [StampW-1:0] wait_i,
  input  logic              cmd_valid_i,
  input  srs_cmd_t          cmd_i,
  output logic              cmd_pop_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output srs_res_t          res_o
);

  srs_bk_state_e      state_q, state_d;
  logic [MaxChunks-1:0] vld_q;
  srs_status_e        st_mem [MaxChunks];
  logic [StampW-1:0]  stamp_mem [MaxChunks];
  srs_status_e        st_rd_q;
  logic               vld_rd_q;
  logic [StampW-1:0]  stamp_rd_q;
  logic [IdxW-1:0]    rd_addr;
  logic [IdxW-1:0]    rd_idx_q;
  logic               rd_pend_q;

  logic               st_we;
  logic [IdxW-1:0]    st_waddr;
  srs_status_e        st_wdata;
  logic               stamp_we;
  logic               vld_clr;

  logic [StampW-1:0]  tick_q, tick_d;
  logic [CntW-1:0]    acked_q, acked_d;
  logic               await_q, await_d;
  logic [IdxW-1:0]    aw_seq_q, aw_seq_d;
  logic               kill_q, kill_d;
  logic               fin_q, fin_d;
  srs_cmd_e           op_q, op_d;
  logic [IdxW-1:0]    seq_q, seq_d;
  logic               settle_q, settle_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               ns_found_q, ns_found_d;
  logic [IdxW-1:0]    ns_idx_q, ns_idx_d;
  logic               f_found_q, f_found_d;
  logic [IdxW-1:0]    f_idx_q, f_idx_d;
  srs_action_e        act_q, act_d;
  logic               out_vld_q, out_vld_d;
  srs_res_t           out_q, out_d;

  srs_status_e        cur_st;
  logic [StampW-1:0]  age;
  logic               kill_go;
  logic               out_free;

  assign cur_st      = vld_rd_q ? st_rd_q : ST_NOT_SENT;
  assign age         = tick_q - stamp_rd_q;
  assign kill_go     = !fin_q && !kill_q && !await_q && (acked_q >= n_i);
  assign out_free    = !out_vld_q || res_ready_i;
  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

  always_comb begin
    state_d    = state_q;
    cmd_pop_o  = 1'b0;
    rd_addr    = (state_q == BK_SCAN) ? cnt_q[IdxW-1:0] : cmd_i.seq;
    st_we      = 1'b0;
    st_waddr   = '0;
    st_wdata   = ST_NOT_SENT;
    stamp_we   = 1'b0;
    vld_clr    = 1'b0;
    tick_d     = tick_q;
    acked_d    = acked_q;
    await_d    = await_q;
    aw_seq_d   = aw_seq_q;
    kill_d     = kill_q;
    fin_d      = fin_q;
    op_d       = op_q;
    seq_d      = seq_q;
    settle_d   = settle_q;
    cnt_d      = cnt_q;
    ns_found_d = ns_found_q;
    ns_idx_d   = ns_idx_q;
    f_found_d  = f_found_q;
    f_idx_d    = f_idx_q;
    act_d      = act_q;
    out_vld_d  = out_vld_q && !res_ready_i;
    out_d      = out_q;

    // scan results arrive in the cycle after the read address
    if (rd_pend_q) begin
      if (cur_st == ST_NOT_SENT && !ns_found_q) begin
        ns_found_d = 1'b1;
        ns_idx_d   = rd_idx_q;
      end
      if (cur_st == ST_FAILED && age > wait_i && !f_found_q) begin
        f_found_d = 1'b1;
        f_idx_d   = rd_idx_q;
      end
    end

    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_i.op;
          seq_d     = cmd_i.seq;
          act_d     = ACT_NONE;
          settle_d  = 1'b0;
          state_d   = BK_FIN;
          unique case (cmd_i.op)
            CMD_CLEAR: begin
              vld_clr  = 1'b1;
              tick_d   = '0;
              acked_d  = '0;
              await_d  = 1'b0;
              aw_seq_d = '0;
              kill_d   = 1'b0;
              fin_d    = 1'b0;
            end
            CMD_TICK: begin
              tick_d = tick_q + StampW'(1);
            end
            CMD_SEND: begin
              if (!fin_q && !await_q) begin
                cnt_d      = '0;
                ns_found_d = 1'b0;
                f_found_d  = 1'b0;
                state_d    = BK_SCAN;
              end
            end
            CMD_ACK: begin
              if (!fin_q) begin
                if (kill_q) begin
                  if (cmd_i.kill_ack) begin
                    st_we    = 1'b1;
                    st_waddr = '0;
                    st_wdata = ST_ACKED;
                    acked_d  = acked_q + CntW'(1);
                    await_d  = 1'b0;
                    fin_d    = 1'b1;
                  end else begin
                    await_d = 1'b0;
                  end
                end else if (cmd_i.kill_ack) begin
                  if (await_q) begin
                    st_we    = 1'b1;
                    st_waddr = aw_seq_q;
                    st_wdata = ST_FAILED;
                    await_d  = 1'b0;
                  end
                end else begin
                  settle_d = await_q && (cmd_i.seq != aw_seq_q);
                  await_d  = 1'b0;
                  state_d  = BK_ACK_WR;
                end
              end
            end
            CMD_CLOSE: begin
              if (!fin_q && await_q) begin
                await_d = 1'b0;
                if (!kill_q) begin
                  st_we    = 1'b1;
                  st_waddr = aw_seq_q;
                  st_wdata = ST_FAILED;
                end
              end
            end
            default: ;
          endcase
        end
      end
      BK_SCAN: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == n_i - CntW'(1)) begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        state_d = BK_PICK;
      end
      BK_PICK: begin
        if (ns_found_q || f_found_q) begin
          seq_d    = ns_found_q ? ns_idx_q : f_idx_q;
          stamp_we = 1'b1;
          await_d  = 1'b1;
          aw_seq_d = ns_found_q ? ns_idx_q : f_idx_q;
          act_d    = ACT_SEND;
        end
        state_d = BK_FIN;
      end
      BK_ACK_WR: begin
        if (cur_st != ST_ACKED) begin
          st_we    = 1'b1;
          st_waddr = seq_q;
          st_wdata = ST_ACKED;
          acked_d  = acked_q + CntW'(1);
        end
        state_d = settle_q ? BK_SETTLE : BK_FIN;
      end
      BK_SETTLE: begin
        st_we    = 1'b1;
        st_waddr = aw_seq_q;
        st_wdata = ST_FAILED;
        state_d  = BK_FIN;
      end
      BK_FIN: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          if (fin_q && op_q != CMD_CLEAR) begin
            out_d.action = ACT_DONE;
            out_d.seq    = '0;
            out_d.kill   = 1'b0;
          end else begin
            out_d.action = act_q;
            out_d.seq    = (act_q == ACT_SEND) ? seq_q : '0;
            out_d.kill   = (act_q == ACT_SEND) && kill_q && (seq_q == '0);
          end
          out_d.acked = acked_q;
          // all chunks done: re-arm chunk 0 as the kill packet
          if (kill_go) begin
            kill_d      = 1'b1;
            st_we       = 1'b1;
            st_waddr    = '0;
            st_wdata    = ST_NOT_SENT;
            acked_d     = acked_q - CntW'(1);
            out_d.acked = acked_q - CntW'(1);
          end
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      vld_q     <= '0;
      tick_q    <= '0;
      acked_q   <= '0;
      await_q   <= 1'b0;
      aw_seq_q  <= '0;
      kill_q    <= 1'b0;
      fin_q     <= 1'b0;
      out_vld_q <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tick_q    <= tick_d;
      acked_q   <= acked_d;
      await_q   <= await_d;
      aw_seq_q  <= aw_seq_d;
      kill_q    <= kill_d;
      fin_q     <= fin_d;
      out_vld_q <= out_vld_d;
      rd_pend_q <= (state_q == BK_SCAN);
      if (vld_clr) begin
        vld_q <= '0;
      end else if (st_we) begin
        vld_q[st_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    seq_q      <= seq_d;
    settle_q   <= settle_d;
    cnt_q      <= cnt_d;
    ns_found_q <= ns_found_d;
    ns_idx_q   <= ns_idx_d;
    f_found_q  <= f_found_d;
    f_idx_q    <= f_idx_d;
    act_q      <= act_d;
    out_q      <= out_d;
    rd_idx_q   <= rd_addr;
    vld_rd_q   <= vld_q[rd_addr];
  end

  // status memory
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    st_rd_q <= st_mem[rd_addr];
  end

  // send stamp memory
  always_ff @(posedge clk_i) begin
    if (stamp_we) begin
      stamp_mem[seq_d] <= tick_q;
    end
    stamp_rd_q <= stamp_mem[rd_addr];
  end

endmodule

// ===== hdl/selective_repeat_sender_scoreboard_top.sv =====
// top level of the selective-repeat sender scoreboard
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tuser opcode, tdata ack_seq
//  m_axis    out  m_axis_tvalid / m_axis_tready   tuser action, tdata seq/kill/total
//  cfg       in   cfg_we_i                        cfg_idx_i, cfg_wdata_i
//
// a send opportunity scans num_chunks entries, one status and stamp read a cycle
// a chunk ack also goes through ack write and, if needed, settle; other words skip both
// a two-word command queue sits between the classifier and the sequencer
// status entries carry valid bits, so reset and start/clear take effect at once
// a full result register holds the sequencer until the word is taken
module selective_repeat_sender_scoreboard_top import srs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // ack_seq
  input  logic [2:0]  s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // send_seq, send_kill, acked_total
  output logic [1:0]  m_axis_tuser,   // action
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [CntW-1:0]   num_q;
  logic [StampW-1:0] wait_q;
  logic [CntW-1:0]   n_lim;
  logic              cmd_valid;
  logic              cmd_pop;
  srs_cmd_t          cmd;
  srs_res_t          res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= DefChunks;
      wait_q <= DefWait;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_CHUNKS: num_q  <= cfg_wdata_i[CntW-1:0];
        CFG_WAIT_TICKS: wait_q <= cfg_wdata_i[StampW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_q == '0) begin
      n_lim = CntW'(1);
    end else if (num_q > CntW'(MaxChunks)) begin
      n_lim = CntW'(MaxChunks);
    end else begin
      n_lim = num_q;
    end
  end

  srs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .n_i           (n_lim),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  srs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (n_lim),
    .wait_i      (wait_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tuser = res.action;
  assign m_axis_tdata = {6'd0, res.acked, res.kill, res.seq};

  a_no_seq_unless_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ACT_SEND) |-> (m_axis_tdata[8:0] == 9'd0))
    else $error("chunk fields set without a transmit");

  a_kill_only_chunk0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("kill bit on a chunk other than 0");

  a_action_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != 2'd3))
    else $error("undefined action code");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[17:9] <= 9'd256))
    else $error("acked total beyond chunk capacity");

endmodule
